// ----- rtl/pav_pkg.sv -----
// shared types and constants for the polyphonic voice allocator
package pav_pkg;

  localparam int NOTE_W  = 7;
  localparam int STAMP_W = 32;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 40;

  localparam logic [NOTE_W-1:0] FULL_LEVEL = 7'd127;

  typedef enum logic [1:0] {
    CMD_NOTE_ON    = 2'd0,
    CMD_NOTE_OFF   = 2'd1,
    CMD_ALL_OFF    = 2'd2,
    CMD_VOICE_DONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef struct packed {
    logic          stolen;
    logic [15:0]   release_mask;
    logic [6:0]    voice_level;
    logic [6:0]    voice_note;
    logic [3:0]    voice_index;
    action_t       action;
  } result_t;

endpackage

// ----- rtl/poly_voice_allocator_core.sv -----
// polyphonic voice allocator: note/stamp memory walked once per note request
// note-on/note-off: one voice read per cycle from the voice memory during the scan;
//   the next request is taken once the result is loaded, which waits for a free output slot
// all-off and voice-done skip the scan and go straight to the result state
// reset (synchronous, rst_n low) clears the active, done and valid flags, the stamp counter and vel_to_level;
// the voice memory needs no clearing since inactive voices never use its contents
module poly_voice_allocator_core #(
  parameter int VOICE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // vel_to_level
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // command[1:0] note[8:2] velocity[15:9] done_voice[19:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // action[1:0] voice_index[5:2] voice_note[12:6]
                                     // voice_level[19:13] release_mask[35:20] stolen[36]
);
  import pav_pkg::*;

  localparam int IW = $clog2(VOICE_COUNT);
  localparam int CW = $clog2(VOICE_COUNT + 1);
  localparam int XW = (IW > 4) ? IW : 4;
  localparam int MW = (VOICE_COUNT > 16) ? VOICE_COUNT : 16;
  localparam int DW = NOTE_W + STAMP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                 state_r;
  cmd_t                   cmd_r;
  logic [NOTE_W-1:0]      note_r;
  logic [NOTE_W-1:0]      vel_r;
  logic [3:0]             dv_r;
  logic                   vel_to_level_r;
  logic [VOICE_COUNT-1:0] active_r;
  logic [VOICE_COUNT-1:0] done_r;
  logic [STAMP_W-1:0]     stamp_cnt_r;

  logic [CW-1:0]          iss_r;
  logic                   rd_vld_r;
  logic [IW-1:0]          rd_idx_r;
  logic                   hit_found_r;
  logic [IW-1:0]          hit_idx_r;
  logic                   free_found_r;
  logic [IW-1:0]          free_idx_r;
  logic [IW-1:0]          best_idx_r;
  logic [STAMP_W-1:0]     best_stamp_r;
  logic [VOICE_COUNT-1:0] mask_r;

  logic                   out_tvalid_r;
  result_t                out_data_r;

  // voice memory: {note, start stamp}
  logic [DW-1:0]          vmem [VOICE_COUNT];
  logic [DW-1:0]          rd_data_r;
  logic                   rd_en;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;

  logic [NOTE_W-1:0]      rd_note;
  logic [STAMP_W-1:0]     rd_stamp;
  logic                   rd_act;
  logic                   rd_free;
  logic                   slot_free;
  logic                   in_fire;
  cmd_t                   in_cmd;
  logic [IW-1:0]          pick_idx;
  logic                   pick_stolen;
  logic [STAMP_W-1:0]     stamp_nxt;
  logic [XW-1:0]          pick_ext;
  logic [XW-1:0]          dv_ext;
  logic                   dv_ok;
  logic [VOICE_COUNT-1:0] rel_mask;
  logic [MW-1:0]          rel_ext;
  result_t                res_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign slot_free  = !out_tvalid_r || out_tready;

  // zero velocity turns a note-on into a note-off
  always_comb begin
    in_cmd = cmd_t'(in_tdata[1:0]);
    if (in_cmd == CMD_NOTE_ON && in_tdata[15:9] == '0) begin
      in_cmd = CMD_NOTE_OFF;
    end
  end

  assign rd_en    = (state_r == S_SCAN) && (iss_r < CW'(VOICE_COUNT));
  assign rd_note  = rd_data_r[DW-1:STAMP_W];
  assign rd_stamp = rd_data_r[STAMP_W-1:0];
  assign rd_act   = active_r[rd_idx_r];
  assign rd_free  = !active_r[rd_idx_r] || done_r[rd_idx_r];

  assign pick_idx    = hit_found_r ? hit_idx_r : (free_found_r ? free_idx_r : best_idx_r);
  assign pick_stolen = !hit_found_r && !free_found_r;
  assign stamp_nxt   = stamp_cnt_r + 1'b1;
  assign pick_ext    = XW'(pick_idx);
  assign dv_ext      = XW'(dv_r);
  assign dv_ok       = (32'(dv_r) < VOICE_COUNT);
  assign rel_mask    = (cmd_r == CMD_ALL_OFF) ? '1 : mask_r;
  assign rel_ext     = MW'(rel_mask);

  assign wr_en   = (state_r == S_RESULT) && slot_free && (cmd_r == CMD_NOTE_ON);
  assign wr_addr = pick_idx;

  always_comb begin
    res_nxt = '0;
    case (cmd_r)
      CMD_NOTE_ON: begin
        res_nxt.action      = ACT_START;
        res_nxt.voice_index = pick_ext[3:0];
        res_nxt.voice_note  = note_r;
        res_nxt.voice_level = vel_to_level_r ? vel_r : FULL_LEVEL;
        res_nxt.stolen      = pick_stolen;
      end
      CMD_NOTE_OFF, CMD_ALL_OFF: begin
        res_nxt.action       = ACT_RELEASE;
        res_nxt.release_mask = rel_ext[15:0];
      end
      default: begin
        res_nxt.action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= {note_r, stamp_nxt};
    end
    if (rd_en) begin
      rd_data_r <= vmem[iss_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      vel_to_level_r <= 1'b0;
      active_r       <= '0;
      done_r         <= '0;
      stamp_cnt_r    <= '0;
      rd_vld_r       <= 1'b0;
      out_tvalid_r   <= 1'b0;
      iss_r          <= '0;
    end else begin
      if (cfg_wr_en) begin
        vel_to_level_r <= cfg_wr_data;
      end
      // in S_RESULT the output register is reloaded below instead
      if (out_tvalid_r && out_tready && state_r != S_RESULT) begin
        out_tvalid_r <= 1'b0;
      end
      rd_vld_r <= rd_en;
      if (rd_en) begin
        rd_idx_r <= iss_r[IW-1:0];
        iss_r    <= iss_r + 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r        <= in_cmd;
            note_r       <= in_tdata[8:2];
            vel_r        <= in_tdata[15:9];
            dv_r         <= in_tdata[19:16];
            iss_r        <= '0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            mask_r       <= '0;
            if (in_cmd == CMD_NOTE_ON || in_cmd == CMD_NOTE_OFF) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld_r) begin
            if (rd_act && rd_note == note_r) begin
              mask_r[rd_idx_r] <= 1'b1;
              if (!hit_found_r) begin
                hit_found_r <= 1'b1;
                hit_idx_r   <= rd_idx_r;
              end
            end
            if (rd_free && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= rd_idx_r;
            end
            // strict less-than keeps the lowest index on equal stamps
            if (rd_idx_r == '0 || rd_stamp < best_stamp_r) begin
              best_idx_r   <= rd_idx_r;
              best_stamp_r <= rd_stamp;
            end
            if (rd_idx_r == IW'(VOICE_COUNT - 1)) begin
              state_r <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= res_nxt;
            state_r      <= S_IDLE;
            if (cmd_r == CMD_NOTE_ON) begin
              active_r[pick_idx] <= 1'b1;
              done_r[pick_idx]   <= 1'b0;
              stamp_cnt_r        <= stamp_nxt;
            end else if (cmd_r == CMD_VOICE_DONE && dv_ok) begin
              done_r[dv_ext[IW-1:0]] <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/poly_voice_allocator_checker.sv -----
// checker for the voice allocator: predicts each request's result and compares the output stream
`timescale 1ns / 1ps

module poly_voice_allocator_checker #(
  parameter int VOICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          outstanding
);
  import pav_pkg::*;

  logic        voice_on   [VOICES];
  logic        voice_fin  [VOICES];
  logic [6:0]  voice_key  [VOICES];
  logic [31:0] voice_age  [VOICES];
  logic [31:0] note_clock;
  logic        level_from_vel;

  result_t     voice_events_due[$];
  int          mismatches = 0;
  int          due_count  = 0;

  assign fail_count  = mismatches;
  assign outstanding = due_count;

  function automatic result_t voice_event_for(input logic [23:0] req);
    cmd_t       c;
    logic [6:0] n;
    logic [6:0] v;
    logic [3:0] dv;
    result_t    r;
    int         pick;
    logic       found;
    c  = cmd_t'(req[1:0]);
    n  = req[8:2];
    v  = req[15:9];
    dv = req[19:16];
    r  = '0;
    if (c == CMD_NOTE_ON && v != 7'd0) begin
      found = 1'b0;
      pick  = 0;
      // retrigger beats a free voice, a free voice beats stealing
      for (int i = 0; i < VOICES; i++) begin
        if (!found && voice_on[i] && voice_key[i] == n) begin
          pick  = i;
          found = 1'b1;
        end
      end
      for (int i = 0; i < VOICES; i++) begin
        if (!found && (!voice_on[i] || voice_fin[i])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        pick = 0;
        for (int i = 1; i < VOICES; i++) begin
          if (voice_age[i] < voice_age[pick]) pick = i;
        end
        r.stolen = 1'b1;
      end
      note_clock      = note_clock + 32'd1;
      voice_fin[pick] = 1'b0;
      voice_on[pick]  = 1'b1;
      voice_key[pick] = n;
      voice_age[pick] = note_clock;
      r.action        = ACT_START;
      r.voice_index   = 4'(pick);
      r.voice_note    = n;
      r.voice_level   = level_from_vel ? v : FULL_LEVEL;
    end else if (c == CMD_NOTE_ON || c == CMD_NOTE_OFF) begin
      r.action = ACT_RELEASE;
      for (int i = 0; i < VOICES && i < 16; i++) begin
        if (voice_on[i] && voice_key[i] == n) r.release_mask[i] = 1'b1;
      end
    end else if (c == CMD_ALL_OFF) begin
      r.action = ACT_RELEASE;
      for (int i = 0; i < VOICES && i < 16; i++) r.release_mask[i] = 1'b1;
    end else if (int'(dv) < VOICES) begin
      voice_fin[dv] = 1'b1;
    end
    return r;
  endfunction

  task automatic compare_voice_event(input logic [39:0] word);
    result_t want;
    result_t got;
    got = result_t'(word[36:0]);
    if (voice_events_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result with no request pending: %h", word);
    end else begin
      want = voice_events_due.pop_front();
      if (got.action !== want.action || got.voice_index !== want.voice_index ||
          got.voice_note !== want.voice_note || got.voice_level !== want.voice_level ||
          got.release_mask !== want.release_mask || got.stolen !== want.stolen ||
          word[39:37] !== 3'b000) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected act=%0d idx=%0d note=%0d lvl=%0d mask=%h stolen=%0d",
                   want.action, want.voice_index, want.voice_note, want.voice_level,
                   want.release_mask, want.stolen);
          $display("  actual act=%0d idx=%0d note=%0d lvl=%0d mask=%h stolen=%0d pad=%b",
                   got.action, got.voice_index, got.voice_note, got.voice_level,
                   got.release_mask, got.stolen, word[39:37]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_on[i]  = 1'b0;
        voice_fin[i] = 1'b0;
        voice_key[i] = '0;
        voice_age[i] = '0;
      end
      note_clock     = '0;
      level_from_vel = 1'b0;
      voice_events_due.delete();
    end else begin
      if (out_tvalid && out_tready) compare_voice_event(out_tdata);
      if (cfg_wr_en) level_from_vel = cfg_wr_data;
      if (in_tvalid && in_tready)
        voice_events_due = {voice_events_due, voice_event_for(in_tdata)};
    end
    due_count <= voice_events_due.size();
  end

endmodule

// ----- tb/poly_voice_allocator_core_test.sv -----
// top of the voice allocator testbench: clock, reset, request stimulus, receiver and verdict
`timescale 1ns / 1ps

module poly_voice_allocator_core_test;
  import pav_pkg::*;

  localparam int     VOICE_COUNT      = 16;
  localparam int     CLK_PERIOD       = 12;
  localparam int     ITEMS_PER_PHASE  = 430;
  localparam int     PRESSURE_ITEMS   = 30;
  localparam int     LONG_HOLD        = 400;
  localparam int     TAIL_CYCLES      = 3 * (VOICE_COUNT + 3);
  localparam longint LIMIT_CYCLES     = 800_000;

  localparam int SEND_PCT [4] = '{0, 59, 0, 20};
  localparam int RECV_PCT [4] = '{0, 0, 59, 20};

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        cfg_wr_en    = 1'b0;
  logic        cfg_wr_data  = 1'b0;
  logic        in_tvalid    = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata     = '0;
  logic        out_tvalid;
  logic        out_tready   = 1'b0;
  logic [39:0] out_tdata;
  logic        hold_ask     = 1'b0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          fail_count;
  int          outstanding;

  poly_voice_allocator_core #(
    .VOICE_COUNT(VOICE_COUNT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  poly_voice_allocator_checker #(
    .VOICES(VOICE_COUNT)
  ) alloc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("poly_voice_allocator_core_test failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off started by a rise of hold_ask
  initial begin : receiver
    int   stall_left;
    logic ask_seen;
    stall_left = 0;
    ask_seen   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !ask_seen) stall_left = LONG_HOLD;
      ask_seen = hold_ask;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [23:0] pack_request(input cmd_t c, input logic [6:0] n,
                                               input logic [6:0] v, input logic [3:0] dv);
    return {4'b0000, dv, v, n, c};
  endfunction

  // notes mostly from a narrow band so retriggers, matching note-offs and steals are common
  function automatic logic [23:0] random_request();
    int         r;
    cmd_t       c;
    logic [6:0] n;
    logic [6:0] v;
    r = $urandom_range(99);
    if (r < 50)      c = CMD_NOTE_ON;
    else if (r < 72) c = CMD_NOTE_OFF;
    else if (r < 77) c = CMD_ALL_OFF;
    else             c = CMD_VOICE_DONE;
    n = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'(60 + $urandom_range(23));
    v = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
    return pack_request(c, n, v, 4'($urandom_range(15)));
  endfunction

  task automatic send_request(input logic [23:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_level_mode(input logic vel_mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= vel_mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_level_mode(1'b0);

    send_request(pack_request(CMD_NOTE_ON, 7'd0, 7'd127, 4'd0));
    send_request(pack_request(CMD_NOTE_ON, 7'd127, 7'd1, 4'd15));
    send_request(pack_request(CMD_NOTE_ON, 7'd0, 7'd64, 4'd0));      // retrigger
    send_request(pack_request(CMD_NOTE_ON, 7'd127, 7'd0, 4'd0));     // zero velocity releases
    send_request(pack_request(CMD_NOTE_OFF, 7'd0, 7'd127, 4'd15));
    send_request(pack_request(CMD_NOTE_OFF, 7'd55, 7'd0, 4'd0));     // nothing holds this note
    send_request(pack_request(CMD_ALL_OFF, 7'd127, 7'd127, 4'd15));
    send_request(pack_request(CMD_VOICE_DONE, 7'd0, 7'd0, 4'd0));
    send_request(pack_request(CMD_NOTE_ON, 7'd10, 7'd100, 4'd0));    // finished voice reused
    send_request(pack_request(CMD_VOICE_DONE, 7'd127, 7'd127, 4'd15)); // idle voice marked done
    for (int k = 0; k < 14; k++)
      send_request(pack_request(CMD_NOTE_ON, 7'(20 + k), 7'(1 + 9 * k), 4'd0));
    send_request(pack_request(CMD_NOTE_ON, 7'd99, 7'd127, 4'd0));    // every voice busy: steal

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_level_mode(~ph[0]);
      send_idle_pct   = SEND_PCT[ph];
      recv_stall_pct <= RECV_PCT[ph];
      repeat (ITEMS_PER_PHASE) send_request(random_request());
    end

    // long receiver hold-off while requests keep coming, then a full drain
    wait_drained();
    write_level_mode(1'b1);
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    hold_ask       <= 1'b1;
    repeat (PRESSURE_ITEMS) send_request(random_request());
    hold_ask       <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("poly_voice_allocator_core_test passed");
    end else begin
      $display("poly_voice_allocator_core_test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pav_pkg.sv
rtl/poly_voice_allocator_core.sv
tb/poly_voice_allocator_checker.sv
tb/poly_voice_allocator_core_test.sv
